// File: design/omnf_pkg.sv
package omnf_pkg;

  // Fixed field widths
  localparam int unsigned MaterialW  = 8;
  localparam int unsigned ColW       = 10;
  localparam int unsigned RowOffW    = 5;
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 6;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 11;

  // Default and fixed limits
  localparam int unsigned MaxRowsDef   = 32;
  localparam int unsigned MaxColumns   = 1024;
  localparam int unsigned MaterialBits = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgWindowWidth  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowHeight = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgIncludeFluid = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgSkipSparse   = 4'd3;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic clear;        // drop all column occupancy
    logic load;         // a pixel word is taken this cycle
    logic shift;        // column ends: current -> previous -> older
    logic occ;          // occupancy of the incoming pixel
    logic skip_sparse;  // neighbour count filter enabled
  } cell_ctrl_t;

  typedef struct packed {
    logic                mask_bit;
    logic [ColW-1:0]     column_offset;
    logic [RowOffW-1:0]  row_offset;
    logic                last_result;
  } res_word_t;

endpackage

// File: design/omnf_if.sv
interface omnf_pix_if;
  logic                               valid;
  logic                               ready;
  logic [omnf_pkg::MaterialW-1:0]     material_id;
  logic                               fluid_flag;

  modport source (output valid, output material_id, output fluid_flag, input ready);
  modport sink   (input valid, input material_id, input fluid_flag, output ready);
endinterface

interface omnf_res_if;
  logic                               valid;
  logic                               ready;
  logic                               mask_bit;
  logic [omnf_pkg::ColW-1:0]          column_offset;
  logic [omnf_pkg::RowOffW-1:0]       row_offset;
  logic                               last_result;

  modport source (output valid, output mask_bit, output column_offset,
                  output row_offset, output last_result, input ready);
  modport sink   (input valid, input mask_bit, input column_offset,
                  input row_offset, input last_result, output ready);
endinterface

// File: design/omnf_cell.sv
// One row of the scan: older, previous and current column occupancy.
module omnf_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  omnf_pkg::cell_ctrl_t ctrl_i,
  input  logic                 row_hit_i,   // incoming pixel lands in this row
  input  logic                 up_ok_i,     // row above lies inside the window
  input  logic                 dn_prev_i,
  input  logic                 dn_cur_i,
  input  logic                 up_prev_i,
  input  logic                 up_cur_i,
  output logic                 prev_o,
  output logic                 cur_o,
  output logic                 emit_mask_o,
  output logic                 flush_mask_o
);

  logic old_q, old_d;
  logic prev_q, prev_d;
  logic cur_q, cur_d;
  logic cur_new;
  logic [2:0] emit_cnt;
  logic [2:0] flush_cnt;

  assign cur_new = (ctrl_i.load && row_hit_i) ? ctrl_i.occ : cur_q;
  assign prev_o  = prev_q;
  assign cur_o   = cur_new;

  // Mid = previous column, right = current column
  always_comb begin
    emit_cnt = 3'(old_q) + 3'(cur_new) + 3'(dn_prev_i) + 3'(up_prev_i && up_ok_i);
    emit_mask_o = prev_q && (!ctrl_i.skip_sparse || emit_cnt > 3'd2);
  end

  // Mid = current column, no right neighbour
  always_comb begin
    flush_cnt = 3'(prev_q) + 3'(dn_cur_i) + 3'(up_cur_i && up_ok_i);
    flush_mask_o = cur_new && (!ctrl_i.skip_sparse || flush_cnt > 3'd2);
  end

  always_comb begin
    old_d  = old_q;
    prev_d = prev_q;
    cur_d  = cur_q;
    if (ctrl_i.clear) begin
      old_d  = 1'b0;
      prev_d = 1'b0;
      cur_d  = 1'b0;
    end else if (ctrl_i.load && ctrl_i.shift) begin
      old_d  = prev_q;
      prev_d = cur_new;
      cur_d  = 1'b0;
    end else if (ctrl_i.load) begin
      cur_d = cur_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_q  <= 1'b0;
      prev_q <= 1'b0;
      cur_q  <= 1'b0;
    end else begin
      old_q  <= old_d;
      prev_q <= prev_d;
      cur_q  <= cur_d;
    end
  end

endmodule

// File: design/omnf_skid.sv
// Two-entry output buffer: output register plus skid register.
module omnf_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  omnf_pkg::res_word_t word_i,
  output logic                full_o,
  omnf_res_if.source          res_o
);

  logic                ov_q, ov_d;
  logic                sv_q, sv_d;
  omnf_pkg::res_word_t ow_q, ow_d;
  omnf_pkg::res_word_t sw_q, sw_d;
  logic                pop;

  assign pop    = ov_q && res_o.ready;
  assign full_o = sv_q;

  always_comb begin
    ov_d = ov_q;
    sv_d = sv_q;
    ow_d = ow_q;
    sw_d = sw_q;
    if (pop) begin
      if (sv_q) begin
        ow_d = sw_q;
        sv_d = 1'b0;
      end else if (push_i) begin
        ow_d = word_i;
      end else begin
        ov_d = 1'b0;
      end
    end else if (push_i) begin
      if (!ov_q) begin
        ov_d = 1'b1;
        ow_d = word_i;
      end else begin
        sv_d = 1'b1;
        sw_d = word_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ow_q <= ow_d;
    sw_q <= sw_d;
  end

  assign res_o.valid         = ov_q;
  assign res_o.mask_bit      = ow_q.mask_bit;
  assign res_o.column_offset = ow_q.column_offset;
  assign res_o.row_offset    = ow_q.row_offset;
  assign res_o.last_result   = ow_q.last_result;

endmodule

// File: design/occupancy_mask_neighbor_filter.sv
// Occupancy mask with four-neighbour filter. Pixels of a window come in
// column by column (row 0 upwards), one word per cycle while ready is high.
// A pixel is occupied when its material is nonzero and it is not fluid (or
// include_fluid is set); with skip_sparse set a kept pixel also needs more
// than two occupied neighbours inside the window. The result word for a
// pixel leaves once its right neighbour has been taken, so nothing comes out
// during the first column. Rate: one pixel per cycle while the result buffer
// has room; after the final pixel of the window a flush hands out one result
// per row of the last column, with input held off meanwhile. Any write to a
// known register restarts the scan; writes to other indexes are ignored.
module occupancy_mask_neighbor_filter #(
  parameter int unsigned MAX_ROWS = omnf_pkg::MaxRowsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [omnf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [omnf_pkg::CfgDataW-1:0]  cfg_data_i,
  omnf_pix_if.sink                       pix_i,
  omnf_res_if.source                     res_o
);

  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW = omnf_pkg::ColW;

  // Configuration registers
  logic [omnf_pkg::WidthRegW-1:0]  width_q;
  logic [omnf_pkg::HeightRegW-1:0] height_q;
  logic                            incl_fluid_q;
  logic                            skip_sparse_q;
  logic                            cfg_hit;

  // Scan position
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;

  // Flush of the final column
  logic                flush_q, flush_d;
  logic [RowW-1:0]     frow_q, frow_d;
  logic [ColW-1:0]     fcol_q, fcol_d;
  logic [MAX_ROWS-1:0] fmask_q, fmask_d;

  logic [6:0]                      eff_h;
  logic [RowW-1:0]                 last_row;
  logic [omnf_pkg::WidthRegW-1:0]  eff_w;
  logic [ColW-1:0]                 last_col;

  logic acc, occ, col_end, win_end;
  logic [omnf_pkg::MaterialBits-1:0] mat;
  logic buf_full;
  logic push;
  omnf_pkg::res_word_t word;
  omnf_pkg::cell_ctrl_t ctrl;

  logic [MAX_ROWS-1:0] row_hit, up_ok, prev_w, cur_w, emit_w, flush_w;

  // Register writes; only known indexes count
  always_comb begin
    case (cfg_idx_i)
      omnf_pkg::CfgWindowWidth,
      omnf_pkg::CfgWindowHeight,
      omnf_pkg::CfgIncludeFluid,
      omnf_pkg::CfgSkipSparse: cfg_hit = cfg_we_i;
      default:                 cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= omnf_pkg::WidthRegW'(1);
      height_q      <= omnf_pkg::HeightRegW'(1);
      incl_fluid_q  <= 1'b0;
      skip_sparse_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        omnf_pkg::CfgWindowWidth:  width_q       <= cfg_data_i[omnf_pkg::WidthRegW-1:0];
        omnf_pkg::CfgWindowHeight: height_q      <= cfg_data_i[omnf_pkg::HeightRegW-1:0];
        omnf_pkg::CfgIncludeFluid: incl_fluid_q  <= cfg_data_i[0];
        omnf_pkg::CfgSkipSparse:   skip_sparse_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective window size: zero acts as one, oversize is clamped
  always_comb begin
    if (height_q == '0)
      eff_h = 7'd1;
    else if (7'(height_q) > 7'(MAX_ROWS))
      eff_h = 7'(MAX_ROWS);
    else
      eff_h = 7'(height_q);
    last_row = RowW'(eff_h - 7'd1);

    if (width_q == '0)
      eff_w = omnf_pkg::WidthRegW'(1);
    else if (width_q > omnf_pkg::WidthRegW'(omnf_pkg::MaxColumns))
      eff_w = omnf_pkg::WidthRegW'(omnf_pkg::MaxColumns);
    else
      eff_w = width_q;
    last_col = ColW'(eff_w - omnf_pkg::WidthRegW'(1));
  end

  // Input side
  assign pix_i.ready = !buf_full && !flush_q;
  assign acc     = pix_i.valid && pix_i.ready;
  assign mat     = pix_i.material_id[omnf_pkg::MaterialBits-1:0];
  assign occ     = (mat != '0) && (incl_fluid_q || !pix_i.fluid_flag);
  assign col_end = (row_q == last_row);
  assign win_end = col_end && (col_q == last_col);

  always_comb begin
    ctrl.clear       = cfg_hit || (acc && win_end);
    ctrl.load        = acc;
    ctrl.shift       = col_end;
    ctrl.occ         = occ;
    ctrl.skip_sparse = skip_sparse_q;
  end

  // Row of cells; each cell sees the cells directly below and above it
  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
    logic dn_prev, dn_cur, up_prev, up_cur;

    assign row_hit[r] = (row_q == RowW'(r));
    assign up_ok[r]   = (RowW'(r) < last_row);

    if (r == 0) begin : g_bot
      assign dn_prev = 1'b0;
      assign dn_cur  = 1'b0;
    end else begin : g_dn
      assign dn_prev = prev_w[r-1];
      assign dn_cur  = cur_w[r-1];
    end

    if (r == MAX_ROWS - 1) begin : g_top
      assign up_prev = 1'b0;
      assign up_cur  = 1'b0;
    end else begin : g_up
      assign up_prev = prev_w[r+1];
      assign up_cur  = cur_w[r+1];
    end

    omnf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .row_hit_i    (row_hit[r]),
      .up_ok_i      (up_ok[r]),
      .dn_prev_i    (dn_prev),
      .dn_cur_i     (dn_cur),
      .up_prev_i    (up_prev),
      .up_cur_i     (up_cur),
      .prev_o       (prev_w[r]),
      .cur_o        (cur_w[r]),
      .emit_mask_o  (emit_w[r]),
      .flush_mask_o (flush_w[r])
    );
  end

  // Scan counters and flush sequencer
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    flush_d = flush_q;
    frow_d  = frow_q;
    fcol_d  = fcol_q;
    fmask_d = fmask_q;
    push    = 1'b0;
    word    = '0;

    if (acc) begin
      // left neighbour of the incoming pixel is now complete
      push               = (col_q != '0);
      word.mask_bit      = emit_w[row_q];
      word.column_offset = col_q - ColW'(1);
      word.row_offset    = omnf_pkg::RowOffW'(row_q);
      word.last_result   = 1'b0;
      if (win_end) begin
        row_d   = '0;
        col_d   = '0;
        flush_d = 1'b1;
        frow_d  = '0;
        fcol_d  = col_q;
        fmask_d = flush_w;
      end else if (col_end) begin
        row_d = '0;
        col_d = col_q + ColW'(1);
      end else begin
        row_d = row_q + RowW'(1);
      end
    end else if (flush_q && !buf_full) begin
      push               = 1'b1;
      word.mask_bit      = fmask_q[0];
      word.column_offset = fcol_q;
      word.row_offset    = omnf_pkg::RowOffW'(frow_q);
      word.last_result   = (frow_q == last_row);
      fmask_d            = fmask_q >> 1;
      if (frow_q == last_row) begin
        flush_d = 1'b0;
      end else begin
        frow_d = frow_q + RowW'(1);
      end
    end

    if (cfg_hit) begin
      row_d = '0;
      col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      flush_q <= 1'b0;
      frow_q  <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      flush_q <= flush_d;
      frow_q  <= frow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fcol_q  <= fcol_d;
    fmask_q <= fmask_d;
  end

  // Result buffer decouples the output handshake from the scan
  omnf_skid u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .word_i (word),
    .full_o (buf_full),
    .res_o  (res_o)
  );

endmodule

// File: bench/omnf_mask_checker.sv
`timescale 1ns / 100ps

// Watches the pixel, result and register ports, predicts every result word
// and compares it with what the block hands out.
module omnf_mask_checker #(
  parameter int unsigned MAX_ROWS = omnf_pkg::MaxRowsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [omnf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [omnf_pkg::CfgDataW-1:0]  cfg_data_i,
  omnf_pix_if                            pix_i,
  omnf_res_if                            res_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    words_due_o,
  output int unsigned                    words_seen_o
);

  localparam int unsigned ColW       = omnf_pkg::ColW;
  localparam int unsigned RowOffW    = omnf_pkg::RowOffW;
  localparam int unsigned MaxReports = 30;

  logic [omnf_pkg::WidthRegW-1:0]  width_q;
  logic [omnf_pkg::HeightRegW-1:0] height_q;
  logic                            fluid_q;
  logic                            skip_q;

  logic [MAX_ROWS-1:0] older_occ;
  logic [MAX_ROWS-1:0] prev_occ;
  logic [MAX_ROWS-1:0] cur_occ;
  int unsigned         col_q;
  int unsigned         row_q;

  omnf_pkg::res_word_t mask_words_due[$];

  function automatic logic pixel_kept(input logic [MAX_ROWS-1:0] left, input bit has_left,
                                      input logic [MAX_ROWS-1:0] mid,
                                      input logic [MAX_ROWS-1:0] right, input bit has_right,
                                      input int unsigned r, input int unsigned h,
                                      input logic skip);
    int unsigned n;
    n = 0;
    if (!mid[r]) return 1'b0;
    if (!skip) return 1'b1;
    if (has_left && left[r]) n++;
    if (has_right && right[r]) n++;
    if (r > 0) begin
      if (mid[r-1]) n++;
    end
    if (r + 1 < h) begin
      if (mid[r+1]) n++;
    end
    return n > 2;
  endfunction

  task automatic clear_scan();
    older_occ = '0;
    prev_occ  = '0;
    cur_occ   = '0;
    col_q     = 0;
    row_q     = 0;
  endtask

  task automatic apply_register(input logic [omnf_pkg::CfgIdxW-1:0] idx,
                                input logic [omnf_pkg::CfgDataW-1:0] data);
    bit known;
    known = 1'b1;
    case (idx)
      omnf_pkg::CfgWindowWidth:  width_q  = data[omnf_pkg::WidthRegW-1:0];
      omnf_pkg::CfgWindowHeight: height_q = data[omnf_pkg::HeightRegW-1:0];
      omnf_pkg::CfgIncludeFluid: fluid_q  = data[0];
      omnf_pkg::CfgSkipSparse:   skip_q   = data[0];
      default:                   known    = 1'b0;
    endcase
    if (known) clear_scan();
  endtask

  task automatic predict_mask_words(input logic [omnf_pkg::MaterialW-1:0] mat,
                                    input logic fl);
    int unsigned         h;
    int unsigned         w;
    int unsigned         x;
    int unsigned         y;
    omnf_pkg::res_word_t word;
    h = (height_q == 0) ? 1 : (height_q > MAX_ROWS) ? MAX_ROWS : height_q;
    w = (width_q == 0) ? 1 :
        (width_q > omnf_pkg::MaxColumns) ? omnf_pkg::MaxColumns : width_q;
    x = (col_q >= w) ? w - 1 : col_q;
    y = (row_q >= h) ? h - 1 : row_q;

    cur_occ[y] = (mat != 0) && (fluid_q || !fl);

    // left neighbour is now complete
    if (x >= 1) begin
      word.mask_bit      = pixel_kept(older_occ, x >= 2, prev_occ, cur_occ, 1'b1, y, h,
                                      skip_q);
      word.column_offset = ColW'(x - 1);
      word.row_offset    = RowOffW'(y);
      word.last_result   = 1'b0;
      mask_words_due.insert(mask_words_due.size(), word);
    end

    if (y == h - 1 && x == w - 1) begin
      // final pixel: flush the last column
      for (int unsigned r = 0; r < h; r++) begin
        word.mask_bit      = pixel_kept(prev_occ, x >= 1, cur_occ, '0, 1'b0, r, h, skip_q);
        word.column_offset = ColW'(x);
        word.row_offset    = RowOffW'(r);
        word.last_result   = (r == h - 1);
        mask_words_due.insert(mask_words_due.size(), word);
      end
      clear_scan();
    end else if (y == h - 1) begin
      older_occ = prev_occ;
      prev_occ  = cur_occ;
      cur_occ   = '0;
      row_q     = 0;
      col_q     = x + 1;
    end else begin
      row_q = y + 1;
      col_q = x;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    omnf_pkg::res_word_t got;
    omnf_pkg::res_word_t want;
    if (!rst_ni) begin
      width_q  = omnf_pkg::WidthRegW'(1);
      height_q = omnf_pkg::HeightRegW'(1);
      fluid_q  = 1'b0;
      skip_q   = 1'b1;
      clear_scan();
      mask_words_due.delete();
      mismatches_o = 0;
      words_seen_o = 0;
    end else begin
      if (cfg_we_i) apply_register(cfg_idx_i, cfg_data_i);
      if (pix_i.valid && pix_i.ready) predict_mask_words(pix_i.material_id, pix_i.fluid_flag);
      if (res_i.valid && res_i.ready) begin
        got.mask_bit      = res_i.mask_bit;
        got.column_offset = res_i.column_offset;
        got.row_offset    = res_i.row_offset;
        got.last_result   = res_i.last_result;
        words_seen_o++;
        if (mask_words_due.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= MaxReports)
            $display("%0t: result word with none due: mask=%0b col=%0d row=%0d last=%0b",
                     $time, got.mask_bit, got.column_offset, got.row_offset,
                     got.last_result);
        end else begin
          want = mask_words_due.pop_front();
          if (got !== want) begin
            mismatches_o++;
            if (mismatches_o <= MaxReports)
              $display("%0t: result word mismatch: exp mask=%0b col=%0d row=%0d last=%0b",
                       $time, want.mask_bit, want.column_offset, want.row_offset,
                       want.last_result,
                       " got mask=%0b col=%0d row=%0d last=%0b",
                       got.mask_bit, got.column_offset, got.row_offset,
                       got.last_result);
          end
        end
      end
    end
    words_due_o = mask_words_due.size();
  end

endmodule

// File: bench/occupancy_mask_neighbor_filter_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the occupancy mask filter. Prediction and
// comparison live in the checker beside the block.
module occupancy_mask_neighbor_filter_tb;

  // register index outside the map: must leave the scan alone
  localparam logic [omnf_pkg::CfgIdxW-1:0] CfgUnmapped = 4'd9;

  // cycles to let a last-column flush drain before touching registers
  localparam int unsigned FlushSlack   = 40;
  localparam int unsigned RandomPixels = 285;
  // worst case: every result word held up by the longest stall, taken twice over
  localparam longint unsigned RunLimitNs = 64'd10_000_000;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [omnf_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [omnf_pkg::CfgDataW-1:0] cfg_data;

  omnf_pix_if pix_if ();
  omnf_res_if res_if ();

  int unsigned mismatches;
  int unsigned words_due;
  int unsigned words_seen;
  int unsigned pixels_sent;
  int unsigned settings_used;
  bit          steady;       // no idling on either side for this phase

  occupancy_mask_neighbor_filter i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  omnf_mask_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pix_i        (pix_if),
    .res_i        (res_if),
    .mismatches_o (mismatches),
    .words_due_o  (words_due),
    .words_seen_o (words_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the block hangs
  initial begin
    #(RunLimitNs);
    $display("run limit hit with %0d result words still due", words_due);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // mostly short gaps, the odd long one
  function automatic int unsigned gap_len();
    return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  // result side back-pressure, updated on the falling edge
  initial begin
    int unsigned stall;
    stall        = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
        res_if.ready <= 1'b0;
        stall = gap_len() - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // One pixel word. Valid stays high into the next call when there is no
  // gap, so it is never dropped and raised in the same step.
  task automatic send_pixel(input logic [omnf_pkg::MaterialW-1:0] mat, input logic fl);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 99) < 70) ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.material_id <= mat;
    pix_if.fluid_flag  <= fl;
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
  endtask

  // dense_pct: share of pixels with a nonzero material
  task automatic send_random_pixel(input int unsigned dense_pct);
    logic [omnf_pkg::MaterialW-1:0] mat;
    mat = 0;
    if ($urandom_range(0, 99) < dense_pct)
      mat = ($urandom_range(0, 9) == 0) ? 8'hFF :
            omnf_pkg::MaterialW'($urandom_range(1, 255));
    send_pixel(mat, $urandom_range(0, 3) == 0);
  endtask

  // Stop the pixel stream and wait for every due result word, then slack.
  task automatic hold_input(input int unsigned slack);
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (slack) @(negedge clk);
  endtask

  task automatic write_reg(input logic [omnf_pkg::CfgIdxW-1:0] idx,
                           input logic [omnf_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(input logic [omnf_pkg::WidthRegW-1:0] w,
                            input logic [omnf_pkg::HeightRegW-1:0] h,
                            input logic fluid, input logic skip);
    hold_input(FlushSlack);
    write_reg(omnf_pkg::CfgWindowWidth, w);
    write_reg(omnf_pkg::CfgWindowHeight, omnf_pkg::CfgDataW'(h));
    write_reg(omnf_pkg::CfgIncludeFluid, omnf_pkg::CfgDataW'(fluid));
    write_reg(omnf_pkg::CfgSkipSparse, omnf_pkg::CfgDataW'(skip));
    end_writes();
    settings_used++;
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned eff_w;
    int unsigned eff_h;
    int unsigned count;
    int unsigned dense;
    int unsigned first_random;
    int unsigned phase;
    bit          drain;

    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    pix_if.valid       = 1'b0;
    pix_if.material_id = '0;
    pix_if.fluid_flag  = 1'b0;
    rst_n              = 1'b0;
    steady             = 1'b0;
    pixels_sent        = 0;
    settings_used      = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // -- directed --
    // reset settings: 1x1 window, filter on, so every word is flushed at once
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);

    // 3x3, fluid counts, no filter; unmapped write mid-window must not restart
    set_window(3, 3, 1'b1, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h7F, 1'b1);
    hold_input(FlushSlack);
    write_reg(CfgUnmapped, '1);
    end_writes();
    send_pixel(8'h40, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h02, 1'b1);
    send_pixel(8'hFF, 1'b0);

    // solid 3x3 with the filter: corners drop, edges and centre stay
    set_window(3, 3, 1'b0, 1'b1);
    repeat (9) send_pixel(8'hFF, 1'b0);

    // zero sizes act as one
    set_window(0, 0, 1'b0, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b1);

    // oversize registers clamp to 1024 x 32; start a window and leave it
    set_window('1, '1, 1'b1, 1'b1);
    repeat (3) send_pixel(8'hC8, 1'b0);

    // -- random phases --
    first_random = pixels_sent;
    phase        = 0;
    while (pixels_sent - first_random < RandomPixels) begin
      case ($urandom_range(0, 9))
        0:       w = 1;
        1:       w = 0;
        2:       w = $urandom_range(0, 1) ? 1024 : $urandom_range(1025, 2047);
        default: w = $urandom_range(2, 5);
      endcase
      case ($urandom_range(0, 9))
        0:       h = 1;
        1, 2:    h = 32;
        3:       h = 0;
        4:       h = $urandom_range(33, 63);
        default: h = $urandom_range(2, 6);
      endcase
      eff_w = (w == 0) ? 1 : (w > omnf_pkg::MaxColumns) ? omnf_pkg::MaxColumns : w;
      eff_h = (h == 0) ? 1 : (h > omnf_pkg::MaxRowsDef) ? omnf_pkg::MaxRowsDef : h;
      set_window(omnf_pkg::WidthRegW'(w), omnf_pkg::HeightRegW'(h),
                 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);

      steady = ($urandom_range(0, 3) == 0);
      dense  = $urandom_range(0, 1) ? 90 : 55;
      if (eff_w >= omnf_pkg::MaxColumns) begin
        // wide window: a partial run of columns only
        count = $urandom_range(20, 60);
      end else begin
        count = eff_w * eff_h;
        if (count < 40) count *= $urandom_range(1, 3);
        // now and then a window cut short by the next register write
        if ($urandom_range(0, 4) == 0) count += $urandom_range(0, eff_w * eff_h - 1);
      end
      // keep the total near the planned number of pixel words
      if (count > RandomPixels - (pixels_sent - first_random))
        count = RandomPixels - (pixels_sent - first_random);

      // first phase always drains halfway; later ones sometimes
      drain = (phase == 0) || ($urandom_range(0, 4) == 0);
      for (int unsigned i = 0; i < count; i++) begin
        if (drain && i == count / 2) hold_input(0);
        send_random_pixel(dense);
      end
      phase++;
    end

    steady = 1'b0;
    hold_input(FlushSlack);

    $display("covered %0d pixel words under %0d register settings, %0d result words checked",
             pixels_sent, settings_used, words_seen);
    $display("windows from one pixel to 1024 columns by 32 rows, clamped sizes, fluid and filter");
    if (mismatches == 0 && words_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
